### sv/fifoia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with indexed access and purge: shared definitions
// Operation and status codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fifoia_pkg;

    localparam int DEFAULT_DEPTH     = 64;
    localparam int DEFAULT_WORD_BITS = 32;

    typedef enum logic [2:0] {
        K_PUSH  = 3'd0,
        K_POP   = 3'd1,
        K_READ  = 3'd2,
        K_WRITE = 3'd3,
        K_PURGE = 3'd4,
        K_FILL  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        AS_HEAD = 3'd0,
        AS_TAIL = 3'd1,
        AS_POS  = 3'd2,
        AS_IDX  = 3'd3,
        AS_KEPT = 3'd4
    } t_addr_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_READ,
        S_PURGE_RD,
        S_PURGE_CMP,
        S_PURGE_END,
        S_FILL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic      load;
        logic      status_we;
        t_status   status;
        logic      wr_en;
        t_addr_sel wr_sel;
        logic      wr_from_ram;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      held_inc;
        logic      pop_commit;
        logic      read_commit;
        logic      idx_inc;
        logic      kept_inc;
        logic      purge_finish;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  empty;
        logic  pos_bad;
        logic  scan_last;
        logic  differs;
    } t_dp_sts;

endpackage

### sv/fifoia_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fifoia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/fifoia_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with indexed access and purge: datapath
// Holds the queue store, head slot, fill level, scan pointers and the result
// registers, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module fifoia_dp #(
    parameter int DEPTH     = fifoia_pkg::DEFAULT_DEPTH,
    parameter int WORD_BITS = fifoia_pkg::DEFAULT_WORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_kind,
    input  logic signed [31:0]  i_value,
    input  logic [5:0]          i_position,
    input  fifoia_pkg::t_dp_cmd i_cmd,
    output fifoia_pkg::t_dp_sts o_sts,
    output logic signed [31:0]  o_data,
    output logic [1:0]          o_status,
    output logic [6:0]          o_count,
    output logic [6:0]          o_removed
);

    localparam int AW = $clog2(DEPTH);
    localparam int HW = $clog2(DEPTH + 1);
    localparam int OW = HW + 6;

    fifoia_pkg::t_kind   r_kind;
    fifoia_pkg::t_status r_status;
    logic [WORD_BITS-1:0] r_word;
    logic [5:0]           r_pos;
    logic [AW-1:0]        r_head;
    logic [HW-1:0]        r_held;
    logic [HW-1:0]        r_idx;
    logic [HW-1:0]        r_kept;
    logic [HW-1:0]        r_removed;
    logic [31:0]          r_data;

    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_wdata;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic [AW-1:0]        w_next_head;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [OW-1:0] offset);
        logic [OW:0] sum;
        sum = (OW + 1)'(head) + (OW + 1)'(offset);
        if (sum >= (OW + 1)'(DEPTH)) begin
            sum = sum - (OW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input fifoia_pkg::t_addr_sel sel,
                                              input logic [AW-1:0] head,
                                              input logic [HW-1:0] held,
                                              input logic [5:0]    pos,
                                              input logic [HW-1:0] idx,
                                              input logic [HW-1:0] kept);
        logic [AW-1:0] addr;
        case (sel)
            fifoia_pkg::AS_HEAD: addr = slot(head, '0);
            fifoia_pkg::AS_TAIL: addr = slot(head, OW'(held));
            fifoia_pkg::AS_POS:  addr = slot(head, OW'(pos));
            fifoia_pkg::AS_IDX:  addr = slot(head, OW'(idx));
            fifoia_pkg::AS_KEPT: addr = slot(head, OW'(kept));
            default:             addr = slot(head, '0);
        endcase
        return addr;
    endfunction

    assign w_waddr = addr_of(i_cmd.wr_sel, r_head, r_held, r_pos, r_idx, r_kept);
    assign w_raddr = addr_of(i_cmd.rd_sel, r_head, r_held, r_pos, r_idx, r_kept);
    assign w_wdata = i_cmd.wr_from_ram ? w_rdata : r_word;
    assign w_next_head = slot(r_head, OW'(1));

    fifoia_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_held <= '0;
        end else begin
            if (i_cmd.held_inc) begin
                r_held <= r_held + HW'(1);
            end
            if (i_cmd.pop_commit) begin
                r_head <= w_next_head;
                r_held <= r_held - HW'(1);
            end
            if (i_cmd.purge_finish) begin
                r_held <= r_kept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= fifoia_pkg::t_kind'(i_kind);
            r_word    <= WORD_BITS'($unsigned(i_value));
            r_pos     <= i_position;
            r_data    <= '0;
            r_status  <= fifoia_pkg::ST_OK;
            r_removed <= '0;
            r_idx     <= '0;
            r_kept    <= '0;
        end else begin
            if (i_cmd.status_we) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.pop_commit || i_cmd.read_commit) begin
                r_data <= 32'(w_rdata);
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + HW'(1);
            end
            if (i_cmd.kept_inc) begin
                r_kept <= r_kept + HW'(1);
            end
            if (i_cmd.purge_finish) begin
                r_removed <= r_held - r_kept;
            end
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.full      = (r_held == HW'(DEPTH));
    assign o_sts.empty     = (r_held == '0);
    assign o_sts.pos_bad   = ((HW + 6)'(r_pos) >= (HW + 6)'(r_held));
    assign o_sts.scan_last = (((HW + 1)'(r_idx) + (HW + 1)'(1)) == (HW + 1)'(r_held));
    assign o_sts.differs   = (w_rdata != r_word);

    assign o_data    = r_data;
    assign o_status  = r_status;
    assign o_count   = 7'(r_held);
    assign o_removed = 7'(r_removed);

endmodule

### sv/fifoia_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with indexed access and purge: controller
// Sequences each operation over the datapath and raises the result strobe.
// ----------------------------------------------------------------------------
module fifoia_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  fifoia_pkg::t_dp_sts i_sts,
    output fifoia_pkg::t_dp_cmd o_cmd,
    output logic                busy,
    output logic                o_valid
);

    fifoia_pkg::t_state r_state;
    fifoia_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fifoia_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fifoia_pkg::S_IDLE: begin
                if (start) begin
                    n_state = fifoia_pkg::S_EXEC;
                end
            end
            fifoia_pkg::S_EXEC: begin
                case (i_sts.kind)
                    fifoia_pkg::K_POP: begin
                        n_state = i_sts.empty ? fifoia_pkg::S_DONE : fifoia_pkg::S_POP;
                    end
                    fifoia_pkg::K_READ: begin
                        n_state = i_sts.pos_bad ? fifoia_pkg::S_DONE : fifoia_pkg::S_READ;
                    end
                    fifoia_pkg::K_PURGE: begin
                        n_state = i_sts.empty ? fifoia_pkg::S_DONE : fifoia_pkg::S_PURGE_RD;
                    end
                    fifoia_pkg::K_FILL: begin
                        n_state = i_sts.empty ? fifoia_pkg::S_DONE : fifoia_pkg::S_FILL;
                    end
                    default: begin
                        n_state = fifoia_pkg::S_DONE;
                    end
                endcase
            end
            fifoia_pkg::S_POP:       n_state = fifoia_pkg::S_DONE;
            fifoia_pkg::S_READ:      n_state = fifoia_pkg::S_DONE;
            fifoia_pkg::S_PURGE_RD:  n_state = fifoia_pkg::S_PURGE_CMP;
            fifoia_pkg::S_PURGE_CMP: begin
                n_state = i_sts.scan_last ? fifoia_pkg::S_PURGE_END
                                          : fifoia_pkg::S_PURGE_RD;
            end
            fifoia_pkg::S_PURGE_END: n_state = fifoia_pkg::S_DONE;
            fifoia_pkg::S_FILL: begin
                if (i_sts.scan_last) begin
                    n_state = fifoia_pkg::S_DONE;
                end
            end
            fifoia_pkg::S_DONE:      n_state = fifoia_pkg::S_IDLE;
            default:                 n_state = fifoia_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            fifoia_pkg::S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            fifoia_pkg::S_EXEC: begin
                case (i_sts.kind)
                    fifoia_pkg::K_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = fifoia_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.wr_sel   = fifoia_pkg::AS_TAIL;
                            o_cmd.held_inc = 1'b1;
                        end
                    end
                    fifoia_pkg::K_POP: begin
                        if (i_sts.empty) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = fifoia_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = fifoia_pkg::AS_HEAD;
                        end
                    end
                    fifoia_pkg::K_READ: begin
                        if (i_sts.pos_bad) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = fifoia_pkg::ST_RANGE;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = fifoia_pkg::AS_POS;
                        end
                    end
                    fifoia_pkg::K_WRITE: begin
                        if (i_sts.pos_bad) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = fifoia_pkg::ST_RANGE;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = fifoia_pkg::AS_POS;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            fifoia_pkg::S_POP: begin
                o_cmd.pop_commit = 1'b1;
            end
            fifoia_pkg::S_READ: begin
                o_cmd.read_commit = 1'b1;
            end
            fifoia_pkg::S_PURGE_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = fifoia_pkg::AS_IDX;
            end
            fifoia_pkg::S_PURGE_CMP: begin
                o_cmd.idx_inc = 1'b1;
                if (i_sts.differs) begin
                    o_cmd.wr_en       = 1'b1;
                    o_cmd.wr_sel      = fifoia_pkg::AS_KEPT;
                    o_cmd.wr_from_ram = 1'b1;
                    o_cmd.kept_inc    = 1'b1;
                end
            end
            fifoia_pkg::S_PURGE_END: begin
                o_cmd.purge_finish = 1'b1;
            end
            fifoia_pkg::S_FILL: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = fifoia_pkg::AS_IDX;
                o_cmd.idx_inc = 1'b1;
            end
            fifoia_pkg::S_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

### sv/fifo_with_indexed_access_and_purge_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with indexed access and purge
// Bounded queue of words with push, pop, indexed read and write, purge of a
// value and fill, built as a controller and a datapath around one RAM.
//
//   Channel   Handshake               Fields
//   command   start, busy             i_kind, i_value, i_position
//   result    o_valid (strobe)        o_data, o_status, o_count, o_removed
//
// An item is taken when start is high and busy is low. Push, write, unused
// codes and all rejected operations run the execute and done states; pop
// and read add a commit state. Purge reads and compares each held entry in
// turn through the single registered RAM read port and writes back the kept
// ones in order; fill writes every held entry. On an empty queue both skip
// the walk. The result strobe lasts one cycle and cannot be held off.
// Reset is synchronous and empties the queue.
// ----------------------------------------------------------------------------
module fifo_with_indexed_access_and_purge_core #(
    parameter int DEPTH     = fifoia_pkg::DEFAULT_DEPTH,
    parameter int WORD_BITS = fifoia_pkg::DEFAULT_WORD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_value,
    input  logic [5:0]         i_position,
    output logic               o_valid,
    output logic signed [31:0] o_data,
    output logic [1:0]         o_status,
    output logic [6:0]         o_count,
    output logic [6:0]         o_removed
);

    fifoia_pkg::t_dp_cmd w_cmd;
    fifoia_pkg::t_dp_sts w_sts;

    fifoia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    fifoia_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .i_position (i_position),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_data     (o_data),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_removed  (o_removed)
    );

endmodule

### sv/fifoia_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with indexed access and purge: port checker
// Checks the command and result ports over time.
// ----------------------------------------------------------------------------
module fifoia_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [31:0] o_data,
    input logic [1:0]         o_status,
    input logic [6:0]         o_count,
    input logic [6:0]         o_removed
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("Accepted item did not make the block busy.");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("Result strobe outside an operation.");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("Result strobe not followed by idle.");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == fifoia_pkg::ST_EMPTY |-> o_count == 7'd0 && o_data == 32'sd0)
        else $error("Empty status with entries or data.");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != fifoia_pkg::ST_OK |-> o_removed == 7'd0 && o_data == 32'sd0)
        else $error("Error status with data or removed entries.");

endmodule

bind fifo_with_indexed_access_and_purge_core fifoia_checker u_fifoia_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_data    (o_data),
    .o_status  (o_status),
    .o_count   (o_count),
    .o_removed (o_removed)
);

### verif/tb_fifo_with_indexed_access_and_purge_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the FIFO with indexed access and purge
// A short table of directed operations covers the empty queue, the extremes
// of the word and two error codes. Random phases follow that grow, shrink
// and churn the queue; each result is checked against the table or a model.
// ----------------------------------------------------------------------------
module tb_fifo_with_indexed_access_and_purge_core;

    localparam int QUEUE_DEPTH  = fifoia_pkg::DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 16;

    localparam logic [2:0] K_SPARE_LO = 3'd6;
    localparam logic [2:0] K_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [31:0]  data;
        fifoia_pkg::t_status status;
        logic [6:0]          count;
        logic [6:0]          removed;
    } t_result;

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [5:0]         position;
        bit                 known;
        t_result            known_res;
    } t_op_row;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic               busy;
    logic [2:0]         i_kind     = '0;
    logic signed [31:0] i_value    = '0;
    logic [5:0]         i_position = '0;
    logic               o_valid;
    logic signed [31:0] o_data;
    logic [1:0]         o_status;
    logic [6:0]         o_count;
    logic [6:0]         o_removed;

    logic signed [31:0] queue_words[$];
    t_result            pending_results[$];
    t_op_row            directed_ops[$];

    int    error_count   = 0;
    int    item_count    = 0;
    int    random_count  = 0;
    int    result_count  = 0;
    int    full_hits     = 0;
    int    purged_total  = 0;
    int    kind_hits[8];
    longint cycle_count  = 0;

    fifo_with_indexed_access_and_purge_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .i_position (i_position),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_removed  (o_removed)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result apply_queue_op(logic [2:0] kind, logic signed [31:0] value,
                                               logic [5:0] position);
        t_result            res;
        logic signed [31:0] kept_words[$];
        res = '0;
        res.status = fifoia_pkg::ST_OK;
        case (kind)
            fifoia_pkg::K_PUSH: begin
                if (queue_words.size() >= QUEUE_DEPTH) begin
                    res.status = fifoia_pkg::ST_FULL;
                end else begin
                    queue_words.push_back(value);
                end
            end
            fifoia_pkg::K_POP: begin
                if (queue_words.size() == 0) begin
                    res.status = fifoia_pkg::ST_EMPTY;
                end else begin
                    res.data = queue_words.pop_front();
                end
            end
            fifoia_pkg::K_READ: begin
                if (int'(position) >= queue_words.size()) begin
                    res.status = fifoia_pkg::ST_RANGE;
                end else begin
                    res.data = queue_words[position];
                end
            end
            fifoia_pkg::K_WRITE: begin
                if (int'(position) >= queue_words.size()) begin
                    res.status = fifoia_pkg::ST_RANGE;
                end else begin
                    queue_words[position] = value;
                end
            end
            fifoia_pkg::K_PURGE: begin
                foreach (queue_words[i]) begin
                    if (queue_words[i] != value) begin
                        kept_words.push_back(queue_words[i]);
                    end
                end
                res.removed = 7'(queue_words.size() - kept_words.size());
                queue_words = kept_words;
            end
            fifoia_pkg::K_FILL: begin
                foreach (queue_words[i]) begin
                    queue_words[i] = value;
                end
            end
            default: begin
            end
        endcase
        res.count = 7'(queue_words.size());
        return res;
    endfunction

    function automatic t_op_row op_row(logic [2:0] kind, logic signed [31:0] value,
                                       logic [5:0] position);
        t_op_row row;
        row.kind      = kind;
        row.value     = value;
        row.position  = position;
        row.known     = 1'b0;
        row.known_res = '0;
        return row;
    endfunction

    function automatic t_op_row known_row(logic [2:0] kind, logic signed [31:0] value,
                                          logic [5:0] position, logic signed [31:0] data,
                                          fifoia_pkg::t_status status, int count,
                                          int removed);
        t_op_row row;
        row                   = op_row(kind, value, position);
        row.known             = 1'b1;
        row.known_res.data    = data;
        row.known_res.status  = status;
        row.known_res.count   = 7'(count);
        row.known_res.removed = 7'(removed);
        return row;
    endfunction

    function automatic logic signed [31:0] draw_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4, 5:    return 32'($urandom_range(1, 4));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] draw_position();
        if (queue_words.size() > 0 && $urandom_range(0, 4) != 0) begin
            return 6'($urandom_range(0, queue_words.size() - 1));
        end
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic issue_op(t_op_row row, int gap_max);
        int      gap;
        t_result predicted;
        gap = $urandom_range(0, gap_max);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_kind     <= row.kind;
        i_value    <= row.value;
        i_position <= row.position;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (row.kind == fifoia_pkg::K_PUSH && queue_words.size() >= QUEUE_DEPTH) begin
            full_hits++;
        end
        predicted = apply_queue_op(row.kind, row.value, row.position);
        purged_total += predicted.removed;
        pending_results.push_back(row.known ? row.known_res : predicted);
        kind_hits[row.kind]++;
        item_count++;
    endtask

    task automatic run_phase(int length, int bias, int gap_max);
        int          push_cut;
        int          pop_cut;
        int          roll;
        logic [2:0]  kind;
        logic signed [31:0] value;
        case (bias)
            0:       begin push_cut = 55; pop_cut = 65; end
            1:       begin push_cut = 15; pop_cut = 55; end
            default: begin push_cut = 30; pop_cut = 50; end
        endcase
        repeat (length) begin
            roll = $urandom_range(0, 99);
            if (roll < push_cut) begin
                kind = fifoia_pkg::K_PUSH;
            end else if (roll < pop_cut) begin
                kind = fifoia_pkg::K_POP;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6:   kind = fifoia_pkg::K_READ;
                    7, 8, 9, 10, 11, 12:   kind = fifoia_pkg::K_WRITE;
                    13, 14, 15:            kind = fifoia_pkg::K_PURGE;
                    16, 17:                kind = fifoia_pkg::K_FILL;
                    default:               kind = $urandom_range(0, 1) ? K_SPARE_HI : K_SPARE_LO;
                endcase
            end
            value = draw_word();
            if (kind == fifoia_pkg::K_PURGE && queue_words.size() > 0
                    && $urandom_range(0, 2) != 0) begin
                value = queue_words[$urandom_range(0, queue_words.size() - 1)];
            end
            issue_op(op_row(kind, value, draw_position()), gap_max);
            random_count++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result data=%0d status=%0d count=%0d removed=%0d",
                         $time, o_data, o_status, o_count, o_removed);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_data !== want.data) begin
                    $display("%0t: data expected %0d actual %0d", $time, want.data, o_data);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_status);
                    error_count++;
                end
                if (o_count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d", $time, want.count, o_count);
                    error_count++;
                end
                if (o_removed !== want.removed) begin
                    $display("%0t: removed expected %0d actual %0d", $time, want.removed,
                             o_removed);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic signed [31:0] fill_word;
        foreach (kind_hits[k]) begin
            kind_hits[k] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_ops.push_back(known_row(fifoia_pkg::K_POP, 32'sd9, 6'd0, 0,
                                         fifoia_pkg::ST_EMPTY, 0, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_READ, 32'sd0, 6'd0, 0,
                                         fifoia_pkg::ST_RANGE, 0, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_WRITE, 32'sd5, 6'd0, 0,
                                         fifoia_pkg::ST_RANGE, 0, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_PURGE, 32'sd0, 6'd0, 0,
                                         fifoia_pkg::ST_OK, 0, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_FILL, -32'sd1, 6'd0, 0,
                                         fifoia_pkg::ST_OK, 0, 0));
        directed_ops.push_back(known_row(K_SPARE_LO, 32'sd0, 6'd0, 0,
                                         fifoia_pkg::ST_OK, 0, 0));
        directed_ops.push_back(known_row(K_SPARE_HI, -32'sd1, 6'd63, 0,
                                         fifoia_pkg::ST_OK, 0, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_PUSH, 32'sh7FFF_FFFF, 6'd0, 0,
                                         fifoia_pkg::ST_OK, 1, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_PUSH, 32'sh8000_0000, 6'd63, 0,
                                         fifoia_pkg::ST_OK, 2, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_PUSH, -32'sd1, 6'd0, 0,
                                         fifoia_pkg::ST_OK, 3, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_PUSH, 32'sd0, 6'd0, 0,
                                         fifoia_pkg::ST_OK, 4, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_READ, 32'sd0, 6'd0, 32'sh7FFF_FFFF,
                                         fifoia_pkg::ST_OK, 4, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_READ, 32'sd0, 6'd3, 0,
                                         fifoia_pkg::ST_OK, 4, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_READ, 32'sd0, 6'd4, 0,
                                         fifoia_pkg::ST_RANGE, 4, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_READ, 32'sd0, 6'd63, 0,
                                         fifoia_pkg::ST_RANGE, 4, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_WRITE, 32'sh7FFF_FFFF, 6'd1, 0,
                                         fifoia_pkg::ST_OK, 4, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_WRITE, 32'sd7, 6'd4, 0,
                                         fifoia_pkg::ST_RANGE, 4, 0));
        directed_ops.push_back(known_row(fifoia_pkg::K_PURGE, 32'sh7FFF_FFFF, 6'd0, 0,
                                         fifoia_pkg::ST_OK, 2, 2));
        directed_ops.push_back(known_row(fifoia_pkg::K_READ, 32'sd0, 6'd0, -32'sd1,
                                         fifoia_pkg::ST_OK, 2, 0));
        directed_ops.push_back(op_row(fifoia_pkg::K_FILL, 32'sh55AA_55AA, 6'd0));
        directed_ops.push_back(op_row(fifoia_pkg::K_POP, 32'sd0, 6'd0));
        directed_ops.push_back(op_row(fifoia_pkg::K_WRITE, 32'sh8000_0000, 6'd0));
        directed_ops.push_back(op_row(K_SPARE_LO, 32'sd3, 6'd0));
        directed_ops.push_back(op_row(fifoia_pkg::K_POP, 32'sd0, 6'd0));
        directed_ops.push_back(op_row(fifoia_pkg::K_PURGE, 32'sh8000_0000, 6'd0));

        foreach (directed_ops[n]) begin
            issue_op(directed_ops[n], 3);
        end

        // Drive the queue to full, push into it, then fill it with one word and empty it by one purge.
        while (queue_words.size() < QUEUE_DEPTH) begin
            issue_op(op_row(fifoia_pkg::K_PUSH, draw_word(), draw_position()), 1);
            random_count++;
        end
        repeat (2) begin
            issue_op(op_row(fifoia_pkg::K_PUSH, draw_word(), draw_position()), 2);
            random_count++;
        end
        fill_word = draw_word();
        issue_op(op_row(fifoia_pkg::K_FILL, fill_word, 6'd0), 2);
        issue_op(op_row(fifoia_pkg::K_PURGE, fill_word, 6'd0), 2);
        random_count += 2;

        while (random_count < RANDOM_ITEMS) begin
            run_phase($urandom_range(20, 80), $urandom_range(0, 2),
                      ($urandom_range(0, 3) == 0) ? 0 : 6);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d operations (push %0d, pop %0d, read %0d, write %0d, purge %0d,",
                 item_count, kind_hits[fifoia_pkg::K_PUSH], kind_hits[fifoia_pkg::K_POP],
                 kind_hits[fifoia_pkg::K_READ], kind_hits[fifoia_pkg::K_WRITE],
                 kind_hits[fifoia_pkg::K_PURGE]);
        $display("fill %0d, unused codes %0d); %0d results, %0d pushes into a full queue,",
                 kind_hits[fifoia_pkg::K_FILL], kind_hits[K_SPARE_LO] + kind_hits[K_SPARE_HI],
                 result_count, full_hits);
        $display("%0d entries purged.", purged_total);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/fifoia_pkg.sv
sv/fifoia_ram.sv
sv/fifoia_dp.sv
sv/fifoia_ctrl.sv
sv/fifo_with_indexed_access_and_purge_core.sv
sv/fifoia_checker.sv
verif/tb_fifo_with_indexed_access_and_purge_core.sv
